@@ sv/assert_macros.svh @@
// Assertion macros shared by the checker files of the descriptor ring follower.
// Needs nothing else; each file that asserts includes it by bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// Next-cycle implication, held off while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`endif

@@ sv/drf_pkg.sv @@
// Shared types and constants of the descriptor ring follower.
// Used by the core, the table RAM users and the port checker; depends on nothing.
package drf_pkg;

	// Table geometry
	localparam int TABLE_DEPTH = 512;
	localparam int IDX_W       = $clog2(TABLE_DEPTH);
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

	// Field widths
	localparam int ENTRY_INDEX_W = 9;
	localparam int WORD_W        = 32;
	localparam int ENTRIES_W     = 10;
	localparam int MISS_W        = 4;

	// Stream word layout, lowest field first, padded to whole bytes
	localparam int S_FIELDS_W = ENTRY_INDEX_W + 3 * WORD_W;
	localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
	localparam int M_TDATA_W  = 2 * WORD_W;

	// Sequence check windows and miss limit
	localparam logic [WORD_W-1:0] CNT_WINDOW = 32'd10;
	localparam logic [WORD_W-1:0] TS_WINDOW  = 32'd1280;
	localparam logic [MISS_W-1:0] MISS_LIMIT = 4'd10;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_SEQ_MODE       = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_STREAM_BASE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_IN_USE = 2'd2;

	// Configuration reset values
	localparam logic                 RST_SEQ_MODE       = 1'b0;
	localparam logic [WORD_W-1:0]    RST_STREAM_BASE    = 32'd38464;
	localparam logic [ENTRIES_W-1:0] RST_ENTRIES_IN_USE = 10'd300;

	// Request kinds carried on tuser
	localparam logic REQ_STORE = 1'b0;
	localparam logic REQ_POLL  = 1'b1;

	// Sequence modes
	localparam logic MODE_COUNTER   = 1'b0;
	localparam logic MODE_TIMESTAMP = 1'b1;

	typedef enum logic [1:0] {
		ST_INIT,
		ST_IDLE,
		ST_SCAN,
		ST_CHECK
	} drf_state_t;

endpackage

@@ sv/drf_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; holds the descriptor table columns of the ring follower.
module drf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/descriptor_ring_follower_core.sv @@
// Descriptor ring follower: table RAMs, resync scan and per-tick sequence check.
// Depends on drf_pkg and drf_ram.
//
// Usage:
//   s_* carries one request per transfer: tuser = 0 stores a descriptor
//   (index, sequence, offset, length) in the table, tuser = 1 is a poll tick.
//   m_* carries a frame (address, length) for each poll tick that finds the
//   next descriptor in sequence. cfg_* writes the mode, stream base and ring
//   size; it is always ready; the user must write it only while the block is idle, unchecked.
// Timing:
//   A synced tick first reads the next and current table entries, then
//   checks; on a pass the frame is loaded into the output register. An
//   unsynced tick, or the tenth miss, walks the sequence RAM one entry per
//   cycle, over at most ring size entries.
// Reset:
//   After reset a clearing pass zeroes all TABLE_DEPTH entries, one a cycle,
//   with s_tready low; configuration writes are taken meanwhile.
// Stall:
//   A frame waits in the output register while m_tready is low; the next
//   request is still taken, and a passing tick holds until the register frees.
module descriptor_ring_follower_core
	import drf_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// Request stream
	input  logic                    s_tvalid,
	output logic                    s_tready,
	// s_tdata: entry_index[8:0], entry_seq[40:9], entry_offset[72:41],
	//          entry_length[104:73], zero padding
	input  logic [S_TDATA_W-1:0]    s_tdata,
	// s_tuser: req_type
	input  logic                    s_tuser,
	// Frame stream
	output logic                    m_tvalid,
	input  logic                    m_tready,
	// m_tdata: frame_addr[31:0], frame_len[63:32]
	output logic [M_TDATA_W-1:0]    m_tdata,
	// Configuration writes
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_W-1:0]    cfg_index,
	input  logic [WORD_W-1:0]       cfg_data
);

	// Request fields
	logic [ENTRY_INDEX_W-1:0] in_index;
	logic [WORD_W-1:0]        in_seq;
	logic [WORD_W-1:0]        in_offset;
	logic [WORD_W-1:0]        in_length;

	assign in_index  = s_tdata[ENTRY_INDEX_W-1:0];
	assign in_seq    = s_tdata[ENTRY_INDEX_W +: WORD_W];
	assign in_offset = s_tdata[ENTRY_INDEX_W + WORD_W +: WORD_W];
	assign in_length = s_tdata[ENTRY_INDEX_W + 2 * WORD_W +: WORD_W];

	// Configuration registers
	logic                 seq_mode_q;
	logic [WORD_W-1:0]    stream_base_q;
	logic [ENTRIES_W-1:0] entries_q;

	// Control state
	drf_state_t         state_q, state_d;
	logic [IDX_W-1:0]   clr_q;
	logic [IDX_W-1:0]   cur_q;
	logic [WORD_W-1:0]  ref_q;
	logic [MISS_W-1:0]  miss_q;
	logic               sync_q;
	logic               out_valid_q;
	logic [M_TDATA_W-1:0] out_data_q;

	// Scan pipeline
	logic [CNT_W-1:0]   iss_q;
	logic               scan_vld_s1;
	logic [IDX_W-1:0]   scan_idx_s1;
	logic [WORD_W-1:0]  best_q;
	logic               best_neg_q;

	// RAM ports
	logic                 ram_we;
	logic [IDX_W-1:0]     ram_waddr;
	logic [WORD_W-1:0]    seq_wdata;
	logic [2*WORD_W-1:0]  pay_wdata;
	logic [IDX_W-1:0]     seq_raddr;
	logic [WORD_W-1:0]    seq_rdata;
	logic [2*WORD_W-1:0]  pay_rdata;

	// Derived control
	logic               in_xfer;
	logic               store_xfer;
	logic               poll_xfer;
	logic               idx_ok;
	logic [CNT_W-1:0]   ring_len;
	logic [CNT_W-1:0]   last_idx;
	logic [IDX_W-1:0]   nxt_idx;
	logic [WORD_W-1:0]  rd_val;
	logic [WORD_W-1:0]  diff;
	logic               pass;
	logic               out_free;
	logic [MISS_W-1:0]  miss_inc;
	logic               miss_out;
	logic               scan_gt;
	logic               scan_hit;
	logic               scan_wrap;
	logic               scan_done;
	logic               scan_issue;
	logic               scan_start;

	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;

	// Take requests only while idle
	assign s_tready = (state_q == ST_IDLE);

	assign in_xfer    = s_tvalid && s_tready;
	assign store_xfer = in_xfer && (s_tuser == REQ_STORE);
	assign poll_xfer  = in_xfer && (s_tuser == REQ_POLL);
	assign idx_ok     = (32'(in_index) < 32'(TABLE_DEPTH));

	// Clamp the ring size to 2..TABLE_DEPTH
	always_comb begin
		priority if (entries_q < 10'd2) begin
			ring_len = CNT_W'(2);
		end else if (32'(entries_q) > 32'(TABLE_DEPTH)) begin
			ring_len = CNT_W'(TABLE_DEPTH);
		end else begin
			ring_len = CNT_W'(entries_q);
		end
	end
	assign last_idx = ring_len - CNT_W'(1);
	assign nxt_idx  = (CNT_W'(cur_q) >= last_idx) ? '0 : cur_q + IDX_W'(1);

	// Sequence value as the mode sees it (same RAM port for scan and check)
	assign rd_val = (seq_mode_q == MODE_TIMESTAMP) ? seq_rdata : {16'd0, seq_rdata[15:0]};

	// Check of the next entry against the reference
	assign diff = rd_val - ref_q;
	always_comb begin
		unique case (seq_mode_q)
			MODE_TIMESTAMP: pass = (diff <= TS_WINDOW);
			default:        pass = (diff[15:0] != 16'd0) && (32'(diff[15:0]) <= CNT_WINDOW);
		endcase
	end
	assign out_free = !out_valid_q || m_tready;
	assign miss_inc = miss_q + MISS_W'(1);
	assign miss_out = (miss_inc == MISS_LIMIT);

	// Scan compare against the running maximum
	assign scan_gt    = best_neg_q || (rd_val > best_q);
	assign scan_hit   = scan_vld_s1 && !scan_gt;
	assign scan_wrap  = scan_vld_s1 && scan_gt && (CNT_W'(scan_idx_s1) == last_idx);
	assign scan_done  = scan_hit || scan_wrap;
	assign scan_issue = (iss_q < ring_len);
	assign scan_start = (state_q == ST_IDLE && poll_xfer && !sync_q)
		|| (state_q == ST_CHECK && !pass && miss_out);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_INIT: begin
				if (clr_q == IDX_W'(TABLE_DEPTH - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (poll_xfer) begin
					state_d = sync_q ? ST_CHECK : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_done) begin
					state_d = ST_IDLE;
				end
			end
			ST_CHECK: begin
				priority if (pass) begin
					if (out_free) begin
						state_d = ST_IDLE;
					end
				end else if (miss_out) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_INIT;
		endcase
	end

	// State outputs: RAM port steering
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = IDX_W'(in_index);
		seq_wdata = in_seq;
		pay_wdata = {in_length, in_offset};
		seq_raddr = nxt_idx;
		unique case (state_q)
			ST_INIT: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				seq_wdata = '0;
				pay_wdata = '0;
			end
			ST_IDLE: begin
				ram_we   = store_xfer && idx_ok;
			end
			ST_SCAN: begin
				seq_raddr = iss_q[IDX_W-1:0];
			end
			ST_CHECK: begin
				seq_raddr = nxt_idx;
			end
			default: begin
				ram_we = 1'b0;
			end
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_mode_q    <= RST_SEQ_MODE;
			stream_base_q <= RST_STREAM_BASE;
			entries_q     <= RST_ENTRIES_IN_USE;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_SEQ_MODE:       seq_mode_q    <= cfg_data[0];
				CFG_STREAM_BASE:    stream_base_q <= cfg_data;
				CFG_ENTRIES_IN_USE: entries_q     <= cfg_data[ENTRIES_W-1:0];
				default:            seq_mode_q    <= seq_mode_q;
			endcase
		end
	end

	// Sequencer state, clearing pass and follower state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			clr_q       <= '0;
			cur_q       <= '0;
			ref_q       <= '0;
			miss_q      <= '0;
			sync_q      <= 1'b0;
			out_valid_q <= 1'b0;
			iss_q       <= '0;
			scan_vld_s1 <= 1'b0;
			scan_idx_s1 <= '0;
			best_q      <= '0;
			best_neg_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			// Load a frame on a passing check, drop it once the receiver takes it
			if (state_q == ST_CHECK && pass && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && m_tready) begin
				out_valid_q <= 1'b0;
			end

			if (state_q == ST_INIT) begin
				clr_q <= clr_q + IDX_W'(1);
			end

			// Arm a scan from entry 0
			if (scan_start) begin
				iss_q       <= '0;
				scan_vld_s1 <= 1'b0;
				best_q      <= (seq_mode_q == MODE_TIMESTAMP) ? '0 : '1;
				best_neg_q  <= (seq_mode_q == MODE_COUNTER);
				miss_q      <= '0;
				sync_q      <= 1'b0;
			end

			// Walk the sequence RAM, one read issued and one compare per cycle
			if (state_q == ST_SCAN) begin
				if (scan_issue) begin
					iss_q <= iss_q + CNT_W'(1);
				end
				scan_vld_s1 <= scan_issue && !scan_done;
				scan_idx_s1 <= iss_q[IDX_W-1:0];
				if (scan_vld_s1 && scan_gt) begin
					best_q     <= rd_val;
					best_neg_q <= 1'b0;
				end
				if (scan_done) begin
					cur_q  <= scan_hit ? scan_idx_s1 : '0;
					ref_q  <= scan_hit ? best_q : rd_val;
					miss_q <= '0;
					sync_q <= 1'b1;
				end
			end

			// Advance on a passing check, count a miss otherwise
			if (state_q == ST_CHECK) begin
				if (pass) begin
					if (out_free) begin
						cur_q       <= nxt_idx;
						ref_q       <= rd_val;
						miss_q      <= '0;
					end
				end else if (!miss_out) begin
					miss_q <= miss_inc;
				end
			end
		end
	end

	// Frame payload register
	always_ff @(posedge clk) begin
		if (state_q == ST_CHECK && pass && out_free) begin
			out_data_q <= {pay_rdata[2*WORD_W-1:WORD_W],
				stream_base_q + pay_rdata[WORD_W-1:0]};
		end
	end

	// Sequence column
	drf_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_seq_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(seq_wdata),
		.raddr(seq_raddr),
		.rdata(seq_rdata)
	);

	// Offset and length columns, read at the current entry
	drf_ram #(
		.WIDTH(2 * WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_pay_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(pay_wdata),
		.raddr(cur_q),
		.rdata(pay_rdata)
	);

endmodule

@@ sv/drf_checker.sv @@
// Port-level checker for the descriptor ring follower, bound to the core.
// Depends on drf_pkg and assert_macros.svh.
`include "assert_macros.svh"

module drf_checker
	import drf_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [S_TDATA_W-1:0] s_tdata,
	input logic                 s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic                 cfg_valid,
	input logic                 cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [WORD_W-1:0]    cfg_data
);

	// A stalled frame holds its payload
	`ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// A poll transfer occupies the block for at least the next cycle
	`ASSERT_NEXT(a_poll_busy, clk, arst_n, s_tvalid && s_tready && s_tuser == REQ_POLL, !s_tready)

	// A store transfer finishes in its own cycle
	`ASSERT_NEXT(a_store_fast, clk, arst_n, s_tvalid && s_tready && s_tuser == REQ_STORE, s_tready)

	// A new frame only comes out of poll work, never straight from idle
	`ASSERT_IMPLY(a_frame_from_poll, clk, arst_n, $rose(m_tvalid), $past(!s_tready))

endmodule

bind descriptor_ring_follower_core drf_checker u_drf_checker (.*);

@@ tb/testbench.sv @@
// Self-checking bench for descriptor_ring_follower_core: directed rows, then random phases.
// Depends on drf_pkg and the core; prediction runs in the bench itself.
`timescale 1ns / 1ps

module testbench
	import drf_pkg::*;
();

	localparam int SETTLE_CYCLES   = TABLE_DEPTH + 88;
	localparam int QUIET_LIMIT     = 4000;
	localparam int PHASES          = 8;
	localparam int ITEMS_PER_PHASE = 120;

	typedef enum logic [1:0] {ROW_STORE, ROW_POLL, ROW_CFG} row_op_t;
	typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_FRAME} row_check_t;

	typedef struct packed {
		logic                     kind;
		logic [ENTRY_INDEX_W-1:0] index;
		logic [WORD_W-1:0]        seq;
		logic [WORD_W-1:0]        offset;
		logic [WORD_W-1:0]        length;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0] addr;
		logic [WORD_W-1:0] len;
	} frame_t;

	// seq holds the register value on a ROW_CFG row; cfg_reg is unused on requests
	typedef struct packed {
		row_op_t                  op;
		logic [CFG_IDX_W-1:0]     cfg_reg;
		logic [ENTRY_INDEX_W-1:0] index;
		logic [WORD_W-1:0]        seq;
		logic [WORD_W-1:0]        offset;
		logic [WORD_W-1:0]        length;
		row_check_t               check;
		logic [WORD_W-1:0]        exp_addr;
		logic [WORD_W-1:0]        exp_len;
		logic [3:0]               reps;
	} stim_row_t;

	localparam int DIR_N = 21;
	localparam stim_row_t DIR_ROWS [DIR_N] = '{
		// top entry, outside the ring at reset size
		'{ROW_STORE, CFG_SEQ_MODE, 9'd511, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			CHK_NONE, 32'd0, 32'd0, 4'd1},
		// first tick after reset only resyncs; the next sees equal counters and misses
		'{ROW_POLL, CFG_SEQ_MODE, 9'd0, 32'd0, 32'd0, 32'd0, CHK_NONE, 32'd0, 32'd0, 4'd1},
		'{ROW_POLL, CFG_SEQ_MODE, 9'd0, 32'd0, 32'd0, 32'd0, CHK_NONE, 32'd0, 32'd0, 4'd1},
		// counter step of one passes
		'{ROW_STORE, CFG_SEQ_MODE, 9'd2, 32'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			CHK_NONE, 32'd0, 32'd0, 4'd1},
		'{ROW_POLL, CFG_SEQ_MODE, 9'd0, 32'd0, 32'd0, 32'd0,
			CHK_FRAME, RST_STREAM_BASE, 32'd0, 4'd1},
		// step of ten passes, address wraps
		'{ROW_STORE, CFG_SEQ_MODE, 9'd3, 32'd11, 32'd1, 32'd1, CHK_NONE, 32'd0, 32'd0, 4'd1},
		'{ROW_POLL, CFG_SEQ_MODE, 9'd0, 32'd0, 32'd0, 32'd0,
			CHK_FRAME, RST_STREAM_BASE - 32'd1, 32'hFFFF_FFFF, 4'd1},
		// step of eleven misses; upper half of the sequence is ignored
		'{ROW_STORE, CFG_SEQ_MODE, 9'd4, 32'hFFFF_0016, 32'd0, 32'd0,
			CHK_NONE, 32'd0, 32'd0, 4'd1},
		'{ROW_POLL, CFG_SEQ_MODE, 9'd0, 32'd0, 32'd0, 32'd0, CHK_NONE, 32'd0, 32'd0, 4'd1},
		'{ROW_STORE, CFG_SEQ_MODE, 9'd4, 32'hFFFF_000C, 32'h8000_0000, 32'h8000_0000,
			CHK_NONE, 32'd0, 32'd0, 4'd1},
		'{ROW_POLL, CFG_SEQ_MODE, 9'd0, 32'd0, 32'd0, 32'd0,
			CHK_FRAME, RST_STREAM_BASE + 32'd1, 32'd1, 4'd1},
		// ten misses in a row drop sync and rescan
		'{ROW_POLL, CFG_SEQ_MODE, 9'd0, 32'd0, 32'd0, 32'd0, CHK_NONE, 32'd0, 32'd0, 4'd10},
		// ring below its minimum, switch to timestamps while synced, top base
		'{ROW_CFG, CFG_ENTRIES_IN_USE, 9'd0, 32'd1, 32'd0, 32'd0,
			CHK_MODEL, 32'd0, 32'd0, 4'd1},
		'{ROW_CFG, CFG_SEQ_MODE, 9'd0, 32'(MODE_TIMESTAMP), 32'd0, 32'd0,
			CHK_MODEL, 32'd0, 32'd0, 4'd1},
		'{ROW_CFG, CFG_STREAM_BASE, 9'd0, 32'hFFFF_FFFF, 32'd0, 32'd0,
			CHK_MODEL, 32'd0, 32'd0, 4'd1},
		// timestamp gap at the window edge, then zero gap, then one past the edge
		'{ROW_STORE, CFG_SEQ_MODE, 9'd0, 32'd1280, 32'd2, 32'hA5A5_A5A5,
			CHK_NONE, 32'd0, 32'd0, 4'd1},
		'{ROW_POLL, CFG_SEQ_MODE, 9'd0, 32'd0, 32'd0, 32'd0, CHK_MODEL, 32'd0, 32'd0, 4'd1},
		'{ROW_STORE, CFG_SEQ_MODE, 9'd1, 32'd1280, 32'd5, 32'd7, CHK_NONE, 32'd0, 32'd0, 4'd1},
		'{ROW_POLL, CFG_SEQ_MODE, 9'd0, 32'd0, 32'd0, 32'd0, CHK_MODEL, 32'd0, 32'd0, 4'd1},
		'{ROW_STORE, CFG_SEQ_MODE, 9'd0, 32'd2561, 32'd0, 32'd0, CHK_NONE, 32'd0, 32'd0, 4'd1},
		'{ROW_POLL, CFG_SEQ_MODE, 9'd0, 32'd0, 32'd0, 32'd0, CHK_MODEL, 32'd0, 32'd0, 4'd1}
	};

	localparam logic [ENTRIES_W-1:0] PHASE_RING [PHASES] = '{
		10'd2, 10'd3, 10'd0, 10'd1023, 10'd512, 10'd1, 10'd9, 10'd5
	};

	logic                 clk;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata   = '0;
	logic                 s_tuser   = REQ_STORE;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_SEQ_MODE;
	logic [WORD_W-1:0]    cfg_data  = '0;

	// Bench copy of the registers and the follower state
	logic                 cfg_mode;
	logic [WORD_W-1:0]    cfg_base;
	logic [ENTRIES_W-1:0] cfg_entries;
	logic [WORD_W-1:0]    seq_mem [TABLE_DEPTH];
	logic [WORD_W-1:0]    off_mem [TABLE_DEPTH];
	logic [WORD_W-1:0]    len_mem [TABLE_DEPTH];
	logic [IDX_W-1:0]     cur_entry;
	logic [32:0]          ref_value;
	logic [MISS_W-1:0]    miss_cnt;
	bit                   locked;

	frame_t frames_due [$];

	int errors         = 0;
	int n_stores       = 0;
	int n_polls        = 0;
	int n_frames       = 0;
	int n_writes       = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int quiet_cycles   = 0;

	descriptor_ring_follower_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	task automatic report_error(input string msg);
		if (errors < 100) $display("error: %s", msg);
		errors++;
	endtask

	function automatic int ring_size();
		int n;
		n = int'(cfg_entries);
		if (n < 2) n = 2;
		if (n > TABLE_DEPTH) n = TABLE_DEPTH;
		return n;
	endfunction

	// Counter mode looks at the low half only
	function automatic logic [WORD_W-1:0] ring_value(input int idx);
		if (cfg_mode == MODE_TIMESTAMP) return seq_mem[idx];
		return {16'h0, seq_mem[idx][15:0]};
	endfunction

	// Walk from entry 0 to the first value that does not rise; wrap to 0 if all rise
	task automatic rescan_ring();
		longint best;
		longint v;
		int     pick;
		int     n;
		bit     found;
		n = ring_size();
		best = (cfg_mode == MODE_TIMESTAMP) ? 64'sd0 : -64'sd1;
		pick = 0;
		found = 1'b0;
		for (int i = 0; i < n && !found; i++) begin
			v = longint'({32'h0, ring_value(i)});
			if (v > best) begin
				best = v;
			end else begin
				pick = i;
				found = 1'b1;
			end
		end
		cur_entry = IDX_W'(pick);
		ref_value = best[32:0];
		miss_cnt = '0;
		locked = 1'b1;
	endtask

	// Advance the bench state by one request; report the frame it should release
	task automatic follow_ring(input req_t r, output bit emits, output frame_t f);
		int                n;
		int                cur;
		int                nxt;
		logic [WORD_W-1:0] val;
		logic [WORD_W-1:0] diff;
		logic [15:0]       diff16;
		bit                ok;
		emits = 1'b0;
		f = '0;
		if (r.kind == REQ_STORE) begin
			if (int'(r.index) < TABLE_DEPTH) begin
				seq_mem[r.index] = r.seq;
				off_mem[r.index] = r.offset;
				len_mem[r.index] = r.length;
			end
		end else if (!locked) begin
			rescan_ring();
		end else begin
			n = ring_size();
			cur = int'(cur_entry);
			nxt = (cur >= n - 1) ? 0 : cur + 1;
			val = ring_value(nxt);
			if (cfg_mode == MODE_TIMESTAMP) begin
				diff = val - ref_value[31:0];
				ok = (diff <= TS_WINDOW);
			end else begin
				diff16 = val[15:0] - ref_value[15:0];
				ok = (diff16 >= 16'd1) && (diff16 <= CNT_WINDOW[15:0]);
			end
			if (ok) begin
				emits = 1'b1;
				f.addr = cfg_base + off_mem[cur];
				f.len = len_mem[cur];
				cur_entry = IDX_W'(nxt);
				ref_value = {1'b0, val};
				miss_cnt = '0;
			end else begin
				miss_cnt = miss_cnt + 1'b1;
				if (miss_cnt >= MISS_LIMIT) begin
					locked = 1'b0;
					miss_cnt = '0;
					rescan_ring();
				end
			end
		end
	endtask

	// Offer one request from a falling edge; queue the frame it releases once taken
	task automatic send_req(input req_t r, input row_check_t chk, input frame_t typed);
		bit     emits;
		frame_t f;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= r.kind;
		s_tdata <= {{(S_TDATA_W - S_FIELDS_W){1'b0}}, r.length, r.offset, r.seq, r.index};
		do @(posedge clk); while (!s_tready);
		follow_ring(r, emits, f);
		if (r.kind == REQ_POLL) n_polls++;
		else n_stores++;
		if (chk == CHK_FRAME) frames_due.push_back(typed);
		else if (chk == CHK_MODEL && emits) frames_due.push_back(f);
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SEQ_MODE:       cfg_mode = val[0];
			CFG_STREAM_BASE:    cfg_base = val;
			CFG_ENTRIES_IN_USE: cfg_entries = val[ENTRIES_W-1:0];
			default: ;
		endcase
		n_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Hold requests, let every frame out, then give a full rescan time to finish
	task automatic settle();
		s_tvalid <= 1'b0;
		while (frames_due.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Receiver readiness
	always @(negedge clk) m_tready <= ($urandom_range(99) >= sink_stall_pct);

	// Compare each frame transfer with the oldest expected frame
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (frames_due.size() == 0) begin
				report_error($sformatf("unexpected frame addr %h len %h",
					m_tdata[31:0], m_tdata[63:32]));
			end else begin
				want = frames_due.pop_front();
				if (m_tdata[31:0] !== want.addr)
					report_error($sformatf("frame_addr got %h want %h", m_tdata[31:0], want.addr));
				if (m_tdata[63:32] !== want.len)
					report_error($sformatf("frame_len got %h want %h", m_tdata[63:32], want.len));
				n_frames++;
			end
		end
	end

	// End the run when no transfer happens for too long
	initial begin
		while (quiet_cycles < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("timeout: no transfer in %0d cycles", QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin
		stim_row_t         row;
		req_t              r;
		frame_t            typed;
		logic [WORD_W-1:0] base;
		logic [WORD_W-1:0] stride;
		logic [WORD_W-1:0] prod_seq;
		int                prod_ptr;
		int                pick;
		bit                busy;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			seq_mem[i] = '0;
			off_mem[i] = '0;
			len_mem[i] = '0;
		end
		cfg_mode = RST_SEQ_MODE;
		cfg_base = RST_STREAM_BASE;
		cfg_entries = RST_ENTRIES_IN_USE;
		cur_entry = '0;
		ref_value = '0;
		miss_cnt = '0;
		locked = 1'b0;

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed rows; drain before each run of register writes
		busy = 1'b0;
		for (int i = 0; i < DIR_N; i++) begin
			row = DIR_ROWS[i];
			if (row.op == ROW_CFG) begin
				if (busy) settle();
				busy = 1'b0;
				write_reg(row.cfg_reg, row.seq);
			end else begin
				r.kind = (row.op == ROW_POLL) ? REQ_POLL : REQ_STORE;
				r.index = row.index;
				r.seq = row.seq;
				r.offset = row.offset;
				r.length = row.length;
				typed.addr = row.exp_addr;
				typed.len = row.exp_len;
				for (int k = 0; k < int'(row.reps); k++) send_req(r, row.check, typed);
				busy = 1'b1;
			end
		end

		// Random phases: a producer writes mostly in-window sequences ahead of the follower,
		// mixed with polls and stores of noise
		for (int p = 0; p < PHASES; p++) begin
			settle();
			src_idle_pct = (p % 4 == 1) ? 65 : (p % 4 == 3) ? 13 : 0;
			sink_stall_pct = (p % 4 == 2) ? 65 : (p % 4 == 3) ? 13 : 0;
			case (p)
				1:       base = '0;
				2:       base = 32'hFFFF_FFFF;
				default: base = $urandom();
			endcase
			write_reg(CFG_SEQ_MODE, 32'(p[0] ? MODE_TIMESTAMP : MODE_COUNTER));
			write_reg(CFG_STREAM_BASE, base);
			write_reg(CFG_ENTRIES_IN_USE, 32'(PHASE_RING[p]));
			prod_ptr = (int'(cur_entry) + 1) % ring_size();
			prod_seq = ref_value[31:0];
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				pick = $urandom_range(99);
				r.index = ENTRY_INDEX_W'($urandom_range(TABLE_DEPTH - 1));
				r.seq = $urandom();
				r.offset = $urandom();
				r.length = $urandom();
				if (pick < 45) begin
					r.kind = REQ_POLL;
				end else if (pick < 88) begin
					r.kind = REQ_STORE;
					if ($urandom_range(9) != 0)
						stride = (cfg_mode == MODE_TIMESTAMP) ? $urandom_range(TS_WINDOW)
							: $urandom_range(1, CNT_WINDOW);
					else
						stride = $urandom();
					prod_seq = prod_seq + stride;
					r.index = ENTRY_INDEX_W'(prod_ptr);
					if (cfg_mode == MODE_TIMESTAMP) r.seq = prod_seq;
					else r.seq[15:0] = prod_seq[15:0];
					prod_ptr = (prod_ptr + 1) % ring_size();
				end else begin
					r.kind = REQ_STORE;
				end
				send_req(r, CHK_MODEL, '0);
			end
		end
		settle();

		$display("covered %0d stores and %0d poll ticks over %0d register settings",
			n_stores, n_polls, PHASES + 2);
		$display("compared %0d frames after %0d register writes, %0d errors",
			n_frames, n_writes, errors);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
